@@ sv/lsbw_pkg.sv @@
// Shared types and constants for the LED strip bit-plane writer.
package lsbw_pkg;

    localparam int WORD_W       = 16;
    localparam int STRIP_W      = 4;
    localparam int POS_W        = 6;
    localparam int COLOR_W      = 24;
    localparam int WADDR_W      = 11;
    localparam int BITS_PER_LED = 24;
    localparam int STEP_W       = 5;

    localparam logic OP_SET  = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RMW,
        S_RDREQ,
        S_READ
    } t_state;

    typedef struct packed {
        logic load;
        logic shift;
        logic we;
        logic re;
        logic clear;
        logic rd_zero;
        logic out_load;
    } t_seq_ctl;

endpackage

@@ sv/lsbw_req_if.sv @@
// Request channel: set-pixel and read-word items.
interface lsbw_req_if
    import lsbw_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic                 op;
    logic [STRIP_W-1:0]   strip;
    logic [POS_W-1:0]     led_position;
    logic [COLOR_W-1:0]   color;
    logic [WADDR_W-1:0]   word_address;

    modport source (
        output valid, op, strip, led_position, color, word_address,
        input  ready
    );
    modport sink (
        input  valid, op, strip, led_position, color, word_address,
        output ready
    );
endinterface

@@ sv/lsbw_rsp_if.sv @@
// Response channel: store words returned by read items.
interface lsbw_rsp_if
    import lsbw_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [WORD_W-1:0]   read_data;

    modport source (
        output valid, read_data,
        input  ready
    );
    modport sink (
        input  valid, read_data,
        output ready
    );
endinterface

@@ sv/lsbw_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module lsbw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ sv/lsbw_merge.sv @@
// Bit-serial colour shifter and strip-mask merge into the store word.
module lsbw_merge
    import lsbw_pkg::*;
(
    input  logic               i_clk,
    input  t_seq_ctl           i_ctl,
    input  logic [STRIP_W-1:0] i_strip,
    input  logic [COLOR_W-1:0] i_color,
    input  logic [WORD_W-1:0]  i_rdata,
    output logic [WORD_W-1:0]  o_wdata
);
    logic [COLOR_W-1:0] r_bits;
    logic [COLOR_W-1:0] n_bits;
    logic [WORD_W-1:0]  r_mask;
    logic [WORD_W-1:0]  n_mask;

    always_comb begin
        n_bits = r_bits;
        n_mask = r_mask;
        if (i_ctl.load) begin
            // green first, then red, then blue, each MSB first
            n_bits = {i_color[15:8], i_color[23:16], i_color[7:0]};
            n_mask = {{(WORD_W-1){1'b0}}, 1'b1} << i_strip;
        end else if (i_ctl.shift) begin
            n_bits = {r_bits[COLOR_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        r_bits <= n_bits;
        r_mask <= n_mask;
    end

    always_comb begin
        if (i_ctl.clear) begin
            o_wdata = '0;
        end else begin
            o_wdata = (i_rdata & ~r_mask) | (r_bits[COLOR_W-1] ? r_mask : '0);
        end
    end
endmodule

@@ sv/lsbw_ctrl.sv @@
// Sequencer: clearing pass, read-modify-write walk over 24 words, word reads.
module lsbw_ctrl
    import lsbw_pkg::*;
#(
    parameter int LEDS_PER_STRIP = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic                 i_op,
    input  logic [POS_W-1:0]     i_pos,
    input  logic [WADDR_W-1:0]   i_waddr,
    input  logic                 i_out_free,
    output logic                 o_ready,
    output t_seq_ctl             o_ctl,
    output logic [$clog2(LEDS_PER_STRIP*BITS_PER_LED)-1:0] o_rd_addr,
    output logic [$clog2(LEDS_PER_STRIP*BITS_PER_LED)-1:0] o_wr_addr
);
    localparam int STORE_WORDS = LEDS_PER_STRIP * BITS_PER_LED;
    localparam int AW = $clog2(STORE_WORDS);
    localparam int CW = ((AW > WADDR_W) ? AW : WADDR_W) + 2;
    localparam logic [AW-1:0]     LAST_ADDR = AW'(STORE_WORDS - 1);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(BITS_PER_LED);

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic [AW-1:0]     r_rd_addr, n_rd_addr;
    logic [AW-1:0]     r_wr_addr, n_wr_addr;
    logic              r_rd_zero, n_rd_zero;

    logic [CW-1:0] base_w;
    logic [CW-1:0] addr_w;
    logic          pos_ok;
    logic          addr_ok;
    logic          rmw_re;

    always_comb begin
        base_w  = (CW'(i_pos) << 4) + (CW'(i_pos) << 3);
        addr_w  = CW'(i_waddr);
        pos_ok  = CW'(i_pos) < CW'(LEDS_PER_STRIP);
        addr_ok = addr_w < CW'(STORE_WORDS);
        rmw_re  = r_step != STEP_LAST;
    end

    always_comb begin
        n_state   = r_state;
        n_step    = r_step;
        n_rd_addr = r_rd_addr;
        n_wr_addr = r_wr_addr;
        n_rd_zero = r_rd_zero;
        unique case (r_state)
            S_CLEAR: begin
                n_wr_addr = r_wr_addr + 1'b1;
                if (r_wr_addr == LAST_ADDR) begin
                    n_wr_addr = '0;
                    n_state   = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    if (i_op == OP_READ) begin
                        n_state   = S_RDREQ;
                        n_rd_zero = !addr_ok;
                        if (addr_ok) begin
                            n_rd_addr = addr_w[AW-1:0];
                        end
                    end else if (pos_ok) begin
                        // drop a pixel past the end of the strip
                        n_state   = S_RMW;
                        n_step    = '0;
                        n_rd_addr = base_w[AW-1:0];
                    end
                end
            end
            S_RMW: begin
                n_step = r_step + 1'b1;
                if (rmw_re) begin
                    n_rd_addr = r_rd_addr + 1'b1;
                    n_wr_addr = r_rd_addr;
                end
                if (r_step == STEP_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_RDREQ: begin
                n_state = S_READ;
            end
            S_READ: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_ready = 1'b0;
        o_ctl   = '0;
        o_ctl.rd_zero = r_rd_zero;
        unique case (r_state)
            S_CLEAR: begin
                o_ctl.clear = 1'b1;
                o_ctl.we    = 1'b1;
            end
            S_IDLE: begin
                o_ready    = 1'b1;
                o_ctl.load = i_valid && (i_op == OP_SET) && pos_ok;
            end
            S_RMW: begin
                // read word k while word k-1 is written back
                o_ctl.re    = rmw_re;
                o_ctl.we    = r_step != '0;
                o_ctl.shift = r_step != '0;
            end
            S_RDREQ: begin
                o_ctl.re = !r_rd_zero;
            end
            S_READ: begin
                // keep reading the same word while the output is held
                o_ctl.re       = !r_rd_zero;
                o_ctl.out_load = i_out_free;
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_step    <= '0;
            r_rd_addr <= '0;
            r_wr_addr <= '0;
            r_rd_zero <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_step    <= n_step;
            r_rd_addr <= n_rd_addr;
            r_wr_addr <= n_wr_addr;
            r_rd_zero <= n_rd_zero;
        end
    end

    assign o_rd_addr = r_rd_addr;
    assign o_wr_addr = r_wr_addr;
endmodule

@@ sv/led_strip_bitplane_writer.sv @@
// Top level: bit-plane frame store for sixteen parallel LED strips.
//
// i_req carries items: op 0 sets the 24-bit 0xRRGGBB colour of one LED on
// one strip, op 1 reads one 16-bit store word. o_rsp returns read_data for
// read items only; set-pixel items give no word back.
// After reset a clearing pass writes zero to every store word, one word a
// cycle, LEDS_PER_STRIP*24 words (1536 by default); i_req.ready stays low
// until the pass is done.
// A set-pixel item occupies the block after acceptance: one store word is
// read and written back per colour bit through the single write port of
// the store, with the read of the next word overlapping the write of the
// previous one. The next item is taken once the last word is written.
// A read item reads the store in S_RDREQ and loads o_rsp from S_READ.
// The output register holds a word while the receiver stalls; set-pixel
// items are still taken meanwhile, a following read waits in its final
// step until the register frees.
module led_strip_bitplane_writer
    import lsbw_pkg::*;
#(
    parameter int LEDS_PER_STRIP = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    lsbw_req_if.sink          i_req,
    lsbw_rsp_if.source        o_rsp
);
    localparam int STORE_WORDS = LEDS_PER_STRIP * BITS_PER_LED;
    localparam int AW = $clog2(STORE_WORDS);

    t_seq_ctl          ctl;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     wr_addr;
    logic [WORD_W-1:0] rdata;
    logic [WORD_W-1:0] wdata;
    logic              out_free;

    logic              r_out_valid, n_out_valid;
    logic [WORD_W-1:0] r_out_data, n_out_data;

    assign out_free = !r_out_valid || o_rsp.ready;

    lsbw_ctrl #(
        .LEDS_PER_STRIP (LEDS_PER_STRIP)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_req.valid),
        .i_op       (i_req.op),
        .i_pos      (i_req.led_position),
        .i_waddr    (i_req.word_address),
        .i_out_free (out_free),
        .o_ready    (i_req.ready),
        .o_ctl      (ctl),
        .o_rd_addr  (rd_addr),
        .o_wr_addr  (wr_addr)
    );

    lsbw_merge u_merge (
        .i_clk   (i_clk),
        .i_ctl   (ctl),
        .i_strip (i_req.strip),
        .i_color (i_req.color),
        .i_rdata (rdata),
        .o_wdata (wdata)
    );

    lsbw_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STORE_WORDS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ctl.we),
        .i_waddr (wr_addr),
        .i_wdata (wdata),
        .i_re    (ctl.re),
        .i_raddr (rd_addr),
        .o_rdata (rdata)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        if (ctl.out_load) begin
            n_out_valid = 1'b1;
            n_out_data  = ctl.rd_zero ? '0 : rdata;
        end else if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
        r_out_data <= n_out_data;
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.read_data = r_out_data;

`ifndef SYNTHESIS
    a_no_same_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctl.we && ctl.re) |-> (wr_addr != rd_addr))
        else $error("store read and write hit the same word");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.out_load |-> (!r_out_valid || o_rsp.ready))
        else $error("output word overwritten while stalled");

    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.clear |-> !i_req.ready)
        else $error("item accepted during clearing pass");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.out_load |=> r_out_valid)
        else $error("loaded word not presented");
`endif
endmodule
